[design/smpq_pkg.sv]
// Shared types, codes and defaults for the sorted minimum priority queue.
package smpq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int OCC_W            = 7;

    typedef logic signed [31:0] cost_t;
    typedef logic [15:0]        tag_t;
    typedef logic [OCC_W-1:0]   occ_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // What a cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    // Control word handed from the queue's control logic to each cell.
    typedef struct packed {
        cell_op_t op;
        logic     live;
    } cell_ctrl_t;

endpackage

[design/smpq_cell.sv]
// One slot of the sorted chain: holds a (cost, tag) pair and compares it with the pushed key.
module smpq_cell (
    input  logic               clk,
    input  smpq_pkg::cell_ctrl_t ctrl,
    input  smpq_pkg::cost_t    new_cost,
    input  smpq_pkg::tag_t     new_tag,
    input  smpq_pkg::cost_t    left_cost,
    input  smpq_pkg::tag_t     left_tag,
    input  smpq_pkg::cost_t    right_cost,
    input  smpq_pkg::tag_t     right_tag,
    output smpq_pkg::cost_t    cost,
    output smpq_pkg::tag_t     tag,
    output smpq_pkg::cost_t    cost_nx,
    output smpq_pkg::tag_t     tag_nx,
    output logic               ge
);
    import smpq_pkg::*;

    cost_t cost_reg;
    cost_t cost_next;
    tag_t  tag_reg;
    tag_t  tag_next;

    // A slot past the fill level counts as greater than any key.
    assign ge = !ctrl.live || (cost_reg >= new_cost);

    always_comb
    begin
        unique case (ctrl.op)
            CELL_LOAD_NEW:
            begin
                cost_next = new_cost;
                tag_next  = new_tag;
            end
            CELL_FROM_LEFT:
            begin
                cost_next = left_cost;
                tag_next  = left_tag;
            end
            CELL_FROM_RIGHT:
            begin
                cost_next = right_cost;
                tag_next  = right_tag;
            end
            default:
            begin
                cost_next = cost_reg;
                tag_next  = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
        tag_reg  <= tag_next;
    end

    assign cost    = cost_reg;
    assign tag     = tag_reg;
    assign cost_nx = cost_next;
    assign tag_nx  = tag_next;

endmodule

[design/sorted_min_priority_queue.sv]
// Sorted minimum priority queue built as a chain of compare-and-shift cells.
//
// The queue holds up to CAPACITY (cost, tag) words in a row of cells kept in
// ascending order of signed cost, cell 0 being the front. Every cell compares
// its cost with the incoming key in parallel. On a push the new word lands at
// the first cell whose cost is equal or greater, so among equal costs the
// newest word is served first, and every cell behind it takes its left
// neighbor's contents. On a pop every cell takes its right neighbor's
// contents. One input word is taken per clock cycle while the input is not
// stalled; the insert or remove is done in the cell row, and its result word
// is registered, at the edge that takes the word. Each result reports the
// front entry after the operation (zero cost and tag when empty), the
// occupancy, an empty flag and a status code. A push into a full queue and a
// pop from an empty queue leave the contents unchanged and report status 1
// and 2. The input stalls only while a finished result is held back by the
// output stall. Occupancy is a 7-bit field, so it wraps if CAPACITY exceeds
// 127.
module sorted_min_priority_queue #(
    parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  smpq_pkg::cost_t   new_cost,
    input  smpq_pkg::tag_t    new_tag,
    output logic              out_valid,
    input  logic              out_stall,
    output smpq_pkg::cost_t   head_cost,
    output smpq_pkg::tag_t    head_tag,
    output smpq_pkg::occ_t    occupancy,
    output logic              is_empty,
    output logic [1:0]        status
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;

    cost_t            head_cost_reg;
    tag_t             head_tag_reg;
    occ_t             occupancy_reg;
    logic             is_empty_reg;
    status_t          status_reg;
    status_t          status_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;

    cost_t            cell_cost [CAPACITY];
    tag_t             cell_tag  [CAPACITY];
    cost_t            cell_cost_nx [CAPACITY];
    tag_t             cell_tag_nx  [CAPACITY];
    logic             cell_ge   [CAPACITY];
    cell_ctrl_t       cell_ctrl [CAPACITY];

    // The input is held off only while a result waits on a stalled output.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign do_push = accept && (func == FUNC_PUSH) && !full;
    assign do_pop  = accept && (func == FUNC_POP) && !empty;

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        if (accept)
        begin
            if (func == FUNC_PUSH)
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            else
            begin
                if (empty)
                    status_next = STATUS_EMPTY;
                else
                    count_next = count_reg - 1'b1;
            end
        end
    end

    // Each cell decides on its own move from its compare result and that of
    // its left neighbor: the first cell at or above the key takes the new
    // word, the ones behind it shift one place toward the back.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic prev_ge;
        cost_t left_cost;
        tag_t  left_tag;
        cost_t right_cost;
        tag_t  right_tag;

        if (i == 0)
        begin : g_first
            assign prev_ge   = 1'b0;
            assign left_cost = new_cost;
            assign left_tag  = new_tag;
        end
        else
        begin : g_inner
            assign prev_ge   = cell_ge[i-1];
            assign left_cost = cell_cost[i-1];
            assign left_tag  = cell_tag[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_cost = cell_cost[i];
            assign right_tag  = cell_tag[i];
        end
        else
        begin : g_mid
            assign right_cost = cell_cost[i+1];
            assign right_tag  = cell_tag[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].live = (CNT_W'(i) < count_reg);
            cell_ctrl[i].op   = CELL_HOLD;
            if (do_push)
            begin
                if (cell_ge[i])
                    cell_ctrl[i].op = prev_ge ? CELL_FROM_LEFT : CELL_LOAD_NEW;
            end
            else if (do_pop)
            begin
                cell_ctrl[i].op = CELL_FROM_RIGHT;
            end
        end

        smpq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .new_cost   (new_cost),
            .new_tag    (new_tag),
            .left_cost  (left_cost),
            .left_tag   (left_tag),
            .right_cost (right_cost),
            .right_tag  (right_tag),
            .cost       (cell_cost[i]),
            .tag        (cell_tag[i]),
            .cost_nx    (cell_cost_nx[i]),
            .tag_nx     (cell_tag_nx[i]),
            .ge         (cell_ge[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // The result word describes the queue after the operation, so the front
    // is taken from the next-state value of cell 0.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (count_next == '0)
            begin
                head_cost_reg <= '0;
                head_tag_reg  <= '0;
            end
            else
            begin
                head_cost_reg <= cell_cost_nx[0];
                head_tag_reg  <= cell_tag_nx[0];
            end
            occupancy_reg <= OCC_W'(count_next);
            is_empty_reg  <= (count_next == '0);
            status_reg    <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign head_cost = head_cost_reg;
    assign head_tag  = head_tag_reg;
    assign occupancy = occupancy_reg;
    assign is_empty  = is_empty_reg;
    assign status    = status_reg;

endmodule

[design/smpq_chk.sv]
// Port-level checks for the sorted minimum priority queue, bound to the top level.
module smpq_chk #(
    parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              func,
    input smpq_pkg::cost_t   new_cost,
    input smpq_pkg::tag_t    new_tag,
    input logic              out_valid,
    input logic              out_stall,
    input smpq_pkg::cost_t   head_cost,
    input smpq_pkg::tag_t    head_tag,
    input smpq_pkg::occ_t    occupancy,
    input logic              is_empty,
    input logic [1:0]        status
);
    import smpq_pkg::*;

    // A result held by the output stall must still be offered next cycle.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // The empty flag must agree with the reported occupancy.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (occupancy == '0)) || (CAPACITY > 127))
        else $error("empty flag disagrees with occupancy");

    // An empty queue reports a zero front entry.
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> (head_cost == '0) && (head_tag == '0))
        else $error("empty queue reports a front entry");

    // A refused pop can only happen on an empty queue, and a refused push
    // only on a full one.
    a_refusals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status != STATUS_EMPTY) || is_empty)
                   && ((status != STATUS_FULL) || (occupancy == OCC_W'(CAPACITY))))
        else $error("refusal status does not match occupancy");

endmodule

bind sorted_min_priority_queue smpq_chk #(.CAPACITY(CAPACITY)) u_smpq_chk (.*);
